// ===== rtl/ctad_pkg.sv =====
// shared types and constants for the click timing autoclick detector
// no dependencies; imported by every rtl module of the block
package ctad_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int BTN_BITS    = 2;
  localparam int TIME_BITS   = 32;
  localparam int THR_BITS    = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  localparam logic [THR_BITS-1:0] STREAK_MAX      = 8'd255;
  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 8'd10;

  // event kinds after classification
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PRESS    = 2'd0;
  localparam kind_t KIND_RELEASE  = 2'd1;
  localparam kind_t KIND_INJECTED = 2'd2;

  // input action codes
  localparam logic ACTION_PRESS   = 1'b0;
  localparam logic ACTION_RELEASE = 1'b1;

  // classified event carried through the queue
  typedef struct packed {
    kind_t                kind;
    logic [BTN_BITS-1:0]  button;
    logic [TIME_BITS-1:0] timestamp;
  } cmd_t;

  // queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/ctad_front.sv =====
// front end: accepts input beats and classifies them into queue commands
// depends on ctad_pkg
module ctad_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic [1:0]                   button,
  input  logic [31:0]                  timestamp_ms,
  input  logic                         injected,
  input  ctad_pkg::q_status_t          q_status,
  output logic                         push,
  output ctad_pkg::cmd_t               cmd
);
  import ctad_pkg::*;

  // take a beat whenever the queue has room
  assign in_ready = !q_status.full;
  assign push     = in_valid && !q_status.full;

  // injected events bypass all timing work
  always_comb begin
    if (injected) begin
      cmd.kind = KIND_INJECTED;
    end else if (action == ACTION_RELEASE) begin
      cmd.kind = KIND_RELEASE;
    end else begin
      cmd.kind = KIND_PRESS;
    end
    cmd.button    = button;
    cmd.timestamp = timestamp_ms;
  end

endmodule

// ===== rtl/ctad_queue.sv =====
// short command queue between the front end and the timing back end
// depends on ctad_pkg
module ctad_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ctad_pkg::cmd_t      wr_cmd,
  input  logic                pop,
  output ctad_pkg::cmd_t      rd_cmd,
  output ctad_pkg::q_status_t status
);
  import ctad_pkg::*;

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  assign rd_cmd       = entries[rd_ptr];
  assign status.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

// ===== rtl/ctad_back.sv =====
// back end: per-button timing state, interval and streak logic, result register
// depends on ctad_pkg
module ctad_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ctad_pkg::cmd_t                cmd,
  input  ctad_pkg::q_status_t           q_status,
  output logic                          pop,
  input  logic [ctad_pkg::THR_BITS-1:0] threshold,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    event_button,
  output logic [31:0]                   interval_ms,
  output logic                          interval_valid,
  output logic                          zero_delay,
  output logic                          steady_autoclick,
  output logic                          injected_seen
);
  import ctad_pkg::*;

  logic [TIME_BITS-1:0] press_time    [NUM_BUTTONS];
  logic [TIME_BITS-1:0] release_time  [NUM_BUTTONS];
  logic                 release_seen  [NUM_BUTTONS];
  logic [TIME_BITS-1:0] held_interval [NUM_BUTTONS];
  logic [THR_BITS-1:0]  streak_count  [NUM_BUTTONS];

  logic [BTN_BITS-1:0]  btn;
  logic [TIME_BITS-1:0] hold;
  logic [TIME_BITS-1:0] gap;
  logic                 rearm;
  logic [THR_BITS-1:0]  streak_eff;
  logic [THR_BITS-1:0]  streak_next;
  logic                 steady;

  logic [TIME_BITS-1:0] ival_next;
  logic                 valid_next;
  logic                 zero_next;
  logic                 steady_next;
  logic                 inj_next;

  // take a command when the result register is free or draining
  assign pop = !q_status.empty && (!out_valid || out_ready);

  // interval and streak evaluation for the selected button
  always_comb begin
    btn        = cmd.button;
    hold       = cmd.timestamp - press_time[btn];
    gap        = cmd.timestamp - release_time[btn];
    rearm      = (streak_count[btn] == '0) || (hold != held_interval[btn]);
    streak_eff = rearm ? '0 : streak_count[btn];
    steady     = (streak_eff >= threshold);
    streak_next = (streak_eff < STREAK_MAX) ? streak_eff + 1'b1 : streak_eff;
  end

  // result fields
  always_comb begin
    ival_next   = '0;
    valid_next  = 1'b0;
    zero_next   = 1'b0;
    steady_next = 1'b0;
    inj_next    = 1'b0;
    case (cmd.kind)
      KIND_INJECTED: begin
        inj_next = 1'b1;
      end
      KIND_RELEASE: begin
        ival_next   = hold;
        valid_next  = 1'b1;
        zero_next   = (hold == '0);
        steady_next = (hold != '0) && steady;
      end
      KIND_PRESS: begin
        if (release_seen[btn]) begin
          ival_next  = gap;
          valid_next = 1'b1;
          zero_next  = (gap == '0);
        end
      end
      default: begin
        inj_next = 1'b0;
      end
    endcase
  end

  // per-button state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_time[i]    <= '0;
        release_time[i]  <= '0;
        release_seen[i]  <= 1'b0;
        held_interval[i] <= '0;
        streak_count[i]  <= '0;
      end
    end else if (pop) begin
      case (cmd.kind)
        KIND_PRESS: begin
          press_time[btn] <= cmd.timestamp;
        end
        KIND_RELEASE: begin
          release_time[btn] <= cmd.timestamp;
          release_seen[btn] <= 1'b1;
          if (hold != '0) begin
            if (rearm) begin
              held_interval[btn] <= hold;
            end
            streak_count[btn] <= streak_next;
          end
        end
        default: begin
          release_seen[btn] <= release_seen[btn];
        end
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      event_button     <= btn;
      interval_ms      <= ival_next;
      interval_valid   <= valid_next;
      zero_delay       <= zero_next;
      steady_autoclick <= steady_next;
      injected_seen    <= inj_next;
    end
  end

endmodule

// ===== rtl/click_timing_autoclick_detector.sv =====
// Mouse click timing and autoclick detector. Each button event beat gives exactly
// one result beat: the hold time on a release, the release-to-press gap on a press
// (once a release was seen), zero-interval and steady-autoclick flags, or just the
// injected flag for synthesized events. Sustains one event per cycle unless the
// output stalls. Input is decoupled from the registered output by a four-entry
// command queue, so input keeps flowing while the output is stalled until that
// queue fills. streak_threshold resets to 10; the user must write it through
// cfg_wr_en/cfg_wr_data only while no events are in flight, unchecked by the block.
// top level; depends on ctad_pkg, ctad_front, ctad_queue, ctad_back
module click_timing_autoclick_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [1:0]  button,
  input  logic [31:0] timestamp_ms,
  input  logic        injected,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_button,
  output logic [31:0] interval_ms,
  output logic        interval_valid,
  output logic        zero_delay,
  output logic        steady_autoclick,
  output logic        injected_seen
);
  import ctad_pkg::*;

  logic [THR_BITS-1:0] streak_threshold;
  q_status_t           q_status;
  cmd_t                push_cmd;
  cmd_t                head_cmd;
  logic                push;
  logic                pop;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      streak_threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      streak_threshold <= cfg_wr_data;
    end
  end

  ctad_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .button       (button),
    .timestamp_ms (timestamp_ms),
    .injected     (injected),
    .q_status     (q_status),
    .push         (push),
    .cmd          (push_cmd)
  );

  ctad_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .status (q_status)
  );

  ctad_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd              (head_cmd),
    .q_status         (q_status),
    .pop              (pop),
    .threshold        (streak_threshold),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .event_button     (event_button),
    .interval_ms      (interval_ms),
    .interval_valid   (interval_valid),
    .zero_delay       (zero_delay),
    .steady_autoclick (steady_autoclick),
    .injected_seen    (injected_seen)
  );

endmodule

// ===== tb/sv/click_timing_autoclick_detector_tb.sv =====
// self-checking testbench for click_timing_autoclick_detector: directed and random button events
// predicts every result beat in-line and compares it with the block output, field by field
// depends on ctad_pkg and the rtl of the block only
module click_timing_autoclick_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctad_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          STALL_CYCLES = 400;
  localparam int          REPORT_MAX   = 10;
  localparam logic [31:0] TIME_TOP     = 32'hFFFF_FFFF;

  // one result beat of the block
  typedef struct packed {
    logic [1:0]  btn;
    logic [31:0] ival;
    logic        ival_ok;
    logic        zero;
    logic        steady;
    logic        inj;
  } click_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [1:0]  button;
  logic [31:0] timestamp_ms;
  logic        injected;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  event_button;
  logic [31:0] interval_ms;
  logic        interval_valid;
  logic        zero_delay;
  logic        steady_autoclick;
  logic        injected_seen;

  // predicted per-button timing state
  logic [31:0] press_at       [NUM_BUTTONS];
  logic [31:0] release_at     [NUM_BUTTONS];
  logic        release_seen_q [NUM_BUTTONS];
  logic [31:0] held_ms        [NUM_BUTTONS];
  logic [7:0]  streak         [NUM_BUTTONS];
  logic [7:0]  threshold;
  logic [31:0] fav_hold       [NUM_BUTTONS];

  click_result_t pending_clicks[$];
  int          mismatch_count;
  int unsigned cycle_count;
  bit          quiet;
  logic        stall_req;
  int          stall_left;

  click_timing_autoclick_detector uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .button           (button),
    .timestamp_ms     (timestamp_ms),
    .injected         (injected),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .event_button     (event_button),
    .interval_ms      (interval_ms),
    .interval_valid   (interval_valid),
    .zero_delay       (zero_delay),
    .steady_autoclick (steady_autoclick),
    .injected_seen    (injected_seen)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // expected result of one event, updating the predicted state
  function automatic click_result_t predict_click(input logic act, input logic [1:0] btn,
                                                  input logic [31:0] ts, input logic inj);
    click_result_t r;
    logic [31:0]   hold;
    r     = '0;
    r.btn = btn;
    if (inj) begin
      r.inj = 1'b1;
    end else if (act == ACTION_PRESS) begin
      press_at[btn] = ts;
      if (release_seen_q[btn]) begin
        r.ival    = ts - release_at[btn];
        r.ival_ok = 1'b1;
        r.zero    = (r.ival == '0);
      end
    end else begin
      hold                = ts - press_at[btn];
      r.ival              = hold;
      r.ival_ok           = 1'b1;
      release_at[btn]     = ts;
      release_seen_q[btn] = 1'b1;
      if (hold == '0) begin
        r.zero = 1'b1;
      end else begin
        // a new interval re-arms the streak
        if (streak[btn] == '0 || hold != held_ms[btn]) begin
          held_ms[btn] = hold;
          streak[btn]  = '0;
        end
        r.steady = (streak[btn] >= threshold);
        if (streak[btn] < STREAK_MAX) streak[btn] = streak[btn] + 8'd1;
      end
    end
    return r;
  endfunction

  // offer one event beat, with random idle cycles ahead of it unless quiet is set
  task automatic send_click(input logic act, input logic [1:0] btn, input logic [31:0] ts,
                            input logic inj);
    while (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    button       <= btn;
    timestamp_ms <= ts;
    injected     <= inj;
    do @(posedge clk); while (!in_ready);
    pending_clicks.push_back(predict_click(act, btn, ts, inj));
  endtask

  task automatic press_release(input logic [1:0] btn, input logic [31:0] ts,
                               input logic [31:0] hold);
    send_click(ACTION_PRESS, btn, ts, 1'b0);
    send_click(ACTION_RELEASE, btn, ts + hold, 1'b0);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_clicks.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold = value;
  endtask

  // wrap, first release, press before release, zero gap, injected events
  task automatic test_first_events();
    send_click(ACTION_RELEASE, 2'd1, 32'd0, 1'b0);
    send_click(ACTION_PRESS, 2'd0, TIME_TOP, 1'b0);
    send_click(ACTION_RELEASE, 2'd0, 32'd5, 1'b0);
    send_click(ACTION_PRESS, 2'd0, 32'd5, 1'b0);
    send_click(ACTION_RELEASE, 2'd3, TIME_TOP, 1'b0);
    send_click(ACTION_PRESS, 2'd3, 32'd0, 1'b0);
    send_click(ACTION_RELEASE, 2'd2, TIME_TOP, 1'b1);
    send_click(ACTION_PRESS, 2'd2, 32'd0, 1'b1);
    send_click(ACTION_PRESS, 2'd2, 32'hA5A5_5A5A, 1'b0);
  endtask

  // threshold after reset: eleventh equal hold flags, new hold re-arms
  task automatic test_default_threshold();
    logic [1:0]  b;
    logic [31:0] hold;
    b    = 2'($urandom_range(NUM_BUTTONS - 1));
    hold = $urandom_range(1, 1000);
    repeat (11) press_release(b, $urandom, hold);
    press_release(b, $urandom, hold + 32'd1);
  endtask

  // thresholds of one and zero, zero hold leaves the streak alone
  task automatic test_threshold_edges();
    write_threshold(8'd1);
    press_release(2'd3, $urandom, 32'd7);
    press_release(2'd3, $urandom, 32'd7);
    press_release(2'd3, $urandom, 32'd9);
    press_release(2'd3, $urandom, 32'd0);
    press_release(2'd3, $urandom, 32'd9);
    write_threshold(8'd0);
    press_release(2'd0, $urandom, 32'd4);
  endtask

  // top threshold and the saturating streak counter
  task automatic test_streak_saturation();
    write_threshold(8'd255);
    repeat (258) press_release(2'd2, $urandom, 32'd37);
  endtask

  // mostly well-formed click pairs, some doubles, lone and injected events
  task automatic test_random_sequences(input int rounds);
    logic [1:0]  b;
    logic [31:0] t;
    logic [31:0] hold;
    int          pick;
    int          sel;
    for (int i = 0; i < rounds; i++) begin
      b    = 2'($urandom_range(NUM_BUTTONS - 1));
      t    = $urandom;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 5) fav_hold[b] = $urandom_range(1, 50);
      if (pick < 8) begin
        send_click(1'($urandom_range(1)), b, t, 1'($urandom_range(1)));
      end else if (pick < 14) begin
        send_click(1'($urandom_range(1)), b, t, 1'b1);
      end else if (pick < 20) begin
        send_click(1'($urandom_range(1)), b, t, 1'b0);
      end else if (pick < 26) begin
        // double-click lands as a second press
        send_click(ACTION_PRESS, b, t, 1'b0);
        send_click(ACTION_PRESS, b, t + $urandom_range(0, 300), 1'b0);
        send_click(ACTION_RELEASE, b, t + $urandom_range(0, 600), 1'b0);
      end else begin
        sel = $urandom_range(99);
        if (sel < 60)      hold = fav_hold[b];
        else if (sel < 70) hold = '0;
        else if (sel < 85) hold = $urandom_range(1, 20);
        else               hold = $urandom;
        press_release(b, t, hold);
      end
    end
  endtask

  task automatic test_random_phases();
    write_threshold(8'd2);
    test_random_sequences(35);
    write_threshold(8'd1);
    test_random_sequences(35);
    write_threshold(8'd3);
    test_random_sequences(35);
    write_threshold(8'($urandom_range(4, 12)));
    test_random_sequences(35);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    stall_req <= 1'b1;
    quiet = 1'b1;
    repeat (12) press_release(2'($urandom_range(NUM_BUTTONS - 1)), $urandom,
                              $urandom_range(1, 9));
    quiet = 1'b0;
  endtask

  // long stretch with no idling on either side
  task automatic test_no_idle();
    quiet = 1'b1;
    test_random_sequences(40);
    quiet = 1'b0;
  endtask

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (stall_req) begin
      stall_left = STALL_CYCLES;
      stall_req <= 1'b0;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 30);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    click_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_clicks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result beat: button %0d interval %0d", event_button,
                   interval_ms);
      end else begin
        want = pending_clicks.pop_front();
        if (event_button !== want.btn || interval_ms !== want.ival ||
            interval_valid !== want.ival_ok || zero_delay !== want.zero ||
            steady_autoclick !== want.steady || injected_seen !== want.inj) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result mismatch at cycle %0d", cycle_count);
            $display("  expected btn %0d ival %0d valid %0b zero %0b steady %0b inj %0b",
                     want.btn, want.ival, want.ival_ok, want.zero, want.steady, want.inj);
            $display("  actual   btn %0d ival %0d valid %0b zero %0b steady %0b inj %0b",
                     event_button, interval_ms, interval_valid, zero_delay,
                     steady_autoclick, injected_seen);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    action         = ACTION_PRESS;
    button         = '0;
    timestamp_ms   = '0;
    injected       = 1'b0;
    out_ready      = 1'b0;
    stall_req      = 1'b0;
    stall_left     = 0;
    quiet          = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    threshold      = THRESHOLD_RESET;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      press_at[i]       = '0;
      release_at[i]     = '0;
      release_seen_q[i] = 1'b0;
      held_ms[i]        = '0;
      streak[i]         = '0;
      fav_hold[i]       = $urandom_range(1, 50);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_first_events();
    test_default_threshold();
    test_threshold_edges();
    test_streak_saturation();
    test_random_phases();
    test_backpressure();
    test_no_idle();

    // drain and let any stray beat show up
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_clicks.size() != 0) begin
      mismatch_count++;
      $display("%0d results never arrived", pending_clicks.size());
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
